[rtl/core/rtt_pkg.sv]
// Types and constants for the round-trip time estimator.
package rtt_pkg;

    localparam int unsigned VALUE_W = 24;

    typedef logic [VALUE_W-1:0] value_t;

    typedef enum logic [1:0] {
        CMD_SAMPLE = 2'd0,
        CMD_EXPIRE = 2'd1,
        CMD_CLEAR  = 2'd2
    } cmd_t;

    localparam value_t SAMPLE_FLOOR = 24'd10;
    localparam value_t MIN_FLOOR    = 24'd4;

    localparam value_t LATEST_RESET   = 24'd0;
    localparam value_t MINIMUM_RESET  = 24'd0;
    localparam value_t SMOOTHED_RESET = 24'd100;
    localparam value_t PREVIOUS_RESET = 24'd20;
    localparam value_t DEVIATION_RESET = 24'd20;

endpackage

[rtl/core/rtt_estimator.sv]
// Round-trip time estimator: smoothed RTT, mean deviation and minimum RTT tracking.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------------------
//  in      | request   | in_valid/in_stall   | command, elapsed, peer_delay
//  out     | result    | out_valid/out_stall | latest_sample, minimum_rtt, smoothed_value,
//          |           |                     | previous_smoothed, deviation
//
// Input register, then result register; one request per cycle while out_stall is low.
// The update of the RTT state (one add of 7s+x, one of 3d+|s-x|) sits between the input
// register and the result register, so back-to-back requests see each other's state.
// Reset loads smoothed 100, previous 20, deviation 20, latest and minimum 0.
// A stalled result holds the result register; the input register then holds one more
// request and in_stall rises only when both are full.
module rtt_estimator
    import rtt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,

    input  logic         in_valid,
    output logic         in_stall,
    input  logic [1:0]   command,
    input  logic [23:0]  elapsed,
    input  logic [23:0]  peer_delay,

    output logic         out_valid,
    input  logic         out_stall,
    output logic [23:0]  latest_sample,
    output logic [23:0]  minimum_rtt,
    output logic [23:0]  smoothed_value,
    output logic [23:0]  previous_smoothed,
    output logic [23:0]  deviation
);

    // input register
    logic   in_valid_reg;
    logic [1:0] command_reg;
    value_t delta_reg;
    value_t delay_reg;

    // estimator state
    value_t latest_reg,   latest_next;
    value_t minimum_reg,  minimum_next;
    value_t smoothed_reg, smoothed_next;
    value_t previous_reg, previous_next;
    value_t deviation_reg, deviation_next;

    // result register
    logic   out_valid_reg;
    value_t res_latest_reg;
    value_t res_minimum_reg;
    value_t res_smoothed_reg;
    value_t res_previous_reg;
    value_t res_deviation_reg;

    logic   res_ready;
    logic   advance;
    logic   in_ready;

    value_t sample_floored;
    value_t sample_adj;
    value_t sample_gap;
    value_t expire_gap;
    logic [26:0] smooth_sum;
    logic [25:0] dev_sum;

    assign res_ready = !out_valid_reg || !out_stall;
    assign advance   = in_valid_reg && res_ready;
    assign in_ready  = !in_valid_reg || res_ready;
    assign in_stall  = !in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            command_reg <= command;
            delta_reg   <= elapsed;
            delay_reg   <= peer_delay;
        end
    end

    // sample path
    always_comb
    begin
        sample_floored = (delta_reg > SAMPLE_FLOOR) ? delta_reg : SAMPLE_FLOOR;
        sample_adj     = (sample_floored > delay_reg) ? (sample_floored - delay_reg)
                                                      : sample_floored;
        sample_gap     = (smoothed_reg > sample_adj) ? (smoothed_reg - sample_adj)
                                                     : (sample_adj - smoothed_reg);
        expire_gap     = (smoothed_reg > latest_reg) ? (smoothed_reg - latest_reg)
                                                     : (latest_reg - smoothed_reg);
        // 7s + x and 3d + gap, then drop the fraction bits
        smooth_sum = {smoothed_reg, 3'b000} - {3'b000, smoothed_reg} + {3'b000, sample_adj};
        dev_sum    = {1'b0, deviation_reg, 1'b0} + {2'b00, deviation_reg}
                   + {2'b00, sample_gap};
    end

    always_comb
    begin
        latest_next    = latest_reg;
        minimum_next   = minimum_reg;
        smoothed_next  = smoothed_reg;
        previous_next  = previous_reg;
        deviation_next = deviation_reg;
        unique case (command_reg)
            CMD_SAMPLE:
            begin
                if (delta_reg != '0)
                begin
                    if (minimum_reg == '0 || minimum_reg > delta_reg)
                    begin
                        minimum_next = (delta_reg > MIN_FLOOR) ? delta_reg : MIN_FLOOR;
                    end
                    previous_next = smoothed_reg;
                    latest_next   = sample_adj;
                    if (smoothed_reg == '0)
                    begin
                        // seed from the first sample
                        smoothed_next  = sample_adj;
                        deviation_next = {1'b0, sample_adj[23:1]};
                    end
                    else
                    begin
                        smoothed_next  = smooth_sum[26:3];
                        deviation_next = dev_sum[25:2];
                    end
                end
            end
            CMD_EXPIRE:
            begin
                if (expire_gap > deviation_reg)
                begin
                    deviation_next = expire_gap;
                end
                if (latest_reg > smoothed_reg)
                begin
                    smoothed_next = latest_reg;
                end
            end
            CMD_CLEAR:
            begin
                latest_next    = '0;
                minimum_next   = '0;
                smoothed_next  = '0;
                deviation_next = '0;
            end
            default:
            begin
                latest_next = latest_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latest_reg    <= LATEST_RESET;
            minimum_reg   <= MINIMUM_RESET;
            smoothed_reg  <= SMOOTHED_RESET;
            previous_reg  <= PREVIOUS_RESET;
            deviation_reg <= DEVIATION_RESET;
        end
        else if (advance)
        begin
            latest_reg    <= latest_next;
            minimum_reg   <= minimum_next;
            smoothed_reg  <= smoothed_next;
            previous_reg  <= previous_next;
            deviation_reg <= deviation_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_latest_reg    <= latest_next;
            res_minimum_reg   <= minimum_next;
            res_smoothed_reg  <= smoothed_next;
            res_previous_reg  <= previous_next;
            res_deviation_reg <= deviation_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign latest_sample     = res_latest_reg;
    assign minimum_rtt       = res_minimum_reg;
    assign smoothed_value    = res_smoothed_reg;
    assign previous_smoothed = res_previous_reg;
    assign deviation         = res_deviation_reg;

    // expire only raises the smoothed value
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && command_reg == CMD_EXPIRE |=> smoothed_reg >= $past(smoothed_reg))
        else $error("smoothed value dropped on expire");

    // a real sample saves the old smoothed value
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && command_reg == CMD_SAMPLE && delta_reg != '0
        |=> previous_reg == $past(smoothed_reg))
        else $error("previous smoothed value not saved");

    // clear leaves smoothed and minimum at zero
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && command_reg == CMD_CLEAR |=> smoothed_reg == '0 && minimum_reg == '0)
        else $error("clear did not zero the state");

    // state moves only with a request leaving the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(smoothed_reg) && $stable(deviation_reg) && $stable(minimum_reg))
        else $error("state changed without a request");

    // a recorded minimum never falls below the floor
    assert property (@(posedge clk) disable iff (!rst_n)
        minimum_reg != '0 |-> minimum_reg >= MIN_FLOOR)
        else $error("minimum rtt below floor");

endmodule
